// ===== rtl/ssc_pkg.sv =====
package ssc_pkg;

    localparam int WIDTH_W = 16;
    localparam int STATE_W = 2;
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    typedef logic [WIDTH_W-1:0] t_width;
    typedef logic [STATE_W-1:0] t_state;
    typedef logic [OP_W-1:0]    t_op;

    // shutter status codes
    localparam t_state ST_CLOSED = 2'd0;
    localparam t_state ST_OPEN   = 2'd1;
    localparam t_state ST_MOVING = 2'd2;

    // operation codes
    localparam t_op OP_INIT   = 2'd0;
    localparam t_op OP_CMD    = 2'd1;
    localparam t_op OP_TARGET = 2'd2;
    localparam t_op OP_FRAME  = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_OPEN   = 2'd0;
    localparam logic [1:0] REG_CLOSED = 2'd1;
    localparam logic [1:0] REG_STEP   = 2'd2;

    localparam t_width STEP_RESET = 16'd1;

endpackage

// ===== rtl/servo_shutter_slew_controller_unit.sv =====
// Servo shutter slew controller. Each input word (init, open/close command,
// set target or servo frame) produces exactly one output word carrying the
// servo pulse width and the shutter status (closed, open, moving) after it.
// A frame moves the pulse width one step_width toward the target and clamps
// at the target; in a frame the status turns open only when a downward move
// lands on the open width and closed only when an upward move lands on the
// closed width; an init sets it open or closed directly. Timing: a word is
// taken into an input register, then all of its work (subtract or 17-bit
// add, compare, clamp) is done combinationally into the state and output
// registers, so each output word passes through the input register and then
// the output register, and a new word is accepted every cycle while the
// output side keeps up. The output register decouples the two sides: while
// a result waits, the input register still takes one word.
// Configuration goes through an APB-style port (open_width at 0x0,
// closed_width at 0x4, step_width at 0x8, 16 bits each, pready always high);
// the user writes it only while the block is idle; no logic enforces this.
module servo_shutter_slew_controller_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input word channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [ssc_pkg::OP_W-1:0]     i_operation,
    input  logic                         i_want_open,
    input  logic [ssc_pkg::WIDTH_W-1:0]  i_target_width,
    // output word channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ssc_pkg::WIDTH_W-1:0]  o_pulse_width,
    output logic [ssc_pkg::STATE_W-1:0]  o_shutter_state,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ssc_pkg::DATA_W-1:0]   pwdata,
    output logic [ssc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    // configuration registers
    ssc_pkg::t_width r_open_width;
    ssc_pkg::t_width r_closed_width;
    ssc_pkg::t_width r_step_width;

    // input register
    logic            r_in_valid;
    ssc_pkg::t_op    r_operation;
    logic            r_want_open;
    ssc_pkg::t_width r_target_width;

    // controller state
    ssc_pkg::t_width r_cur;
    ssc_pkg::t_width r_goal;
    ssc_pkg::t_state r_status;

    // output register
    logic            r_out_valid;
    ssc_pkg::t_width r_pulse_width;
    ssc_pkg::t_state r_shutter_state;

    ssc_pkg::t_width n_cur;
    ssc_pkg::t_width n_goal;
    ssc_pkg::t_state n_status;

    logic                       in_accept;
    logic                       advance;
    logic                       cfg_write;
    ssc_pkg::t_width            down_diff;
    logic [ssc_pkg::WIDTH_W:0]  up_sum;

    // ---------------------------------------------------------------
    // handshake: the input register drains whenever the output register
    // is empty or its word is being taken
    // ---------------------------------------------------------------
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_operation    <= i_operation;
            r_want_open    <= i_want_open;
            r_target_width <= i_target_width;
        end
    end

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_width   <= '0;
            r_closed_width <= '0;
            r_step_width   <= ssc_pkg::STEP_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                ssc_pkg::REG_OPEN:   r_open_width   <= pwdata[ssc_pkg::WIDTH_W-1:0];
                ssc_pkg::REG_CLOSED: r_closed_width <= pwdata[ssc_pkg::WIDTH_W-1:0];
                ssc_pkg::REG_STEP:   r_step_width   <= pwdata[ssc_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            ssc_pkg::REG_OPEN:   prdata = {16'd0, r_open_width};
            ssc_pkg::REG_CLOSED: prdata = {16'd0, r_closed_width};
            ssc_pkg::REG_STEP:   prdata = {16'd0, r_step_width};
            default:             prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // next state for the word in the input register
    // ---------------------------------------------------------------
    assign down_diff = r_cur - r_goal;
    assign up_sum    = {1'b0, r_cur} + {1'b0, r_step_width};

    always_comb begin
        n_cur    = r_cur;
        n_goal   = r_goal;
        n_status = r_status;
        case (r_operation)
            ssc_pkg::OP_INIT: begin
                n_status = r_want_open ? ssc_pkg::ST_OPEN : ssc_pkg::ST_CLOSED;
                n_cur    = r_want_open ? r_open_width : r_closed_width;
                n_goal   = n_cur;
            end
            ssc_pkg::OP_CMD: begin
                if (r_want_open && r_status != ssc_pkg::ST_OPEN) begin
                    n_goal   = r_open_width;
                    n_status = ssc_pkg::ST_MOVING;
                end else if (!r_want_open && r_status != ssc_pkg::ST_CLOSED) begin
                    n_goal   = r_closed_width;
                    n_status = ssc_pkg::ST_MOVING;
                end
            end
            ssc_pkg::OP_TARGET: begin
                n_goal = r_target_width;
            end
            ssc_pkg::OP_FRAME: begin
                if (r_cur > r_goal) begin
                    // moving down: clamp when the step covers the gap
                    if (r_step_width >= down_diff) begin
                        n_cur = r_goal;
                        if (r_goal == r_open_width) begin
                            n_status = ssc_pkg::ST_OPEN;
                        end
                    end else begin
                        n_cur = r_cur - r_step_width;
                    end
                end else if (r_cur < r_goal) begin
                    // moving up: sum is one bit wider, so no wrap
                    if (up_sum >= {1'b0, r_goal}) begin
                        n_cur = r_goal;
                        if (r_goal == r_closed_width) begin
                            n_status = ssc_pkg::ST_CLOSED;
                        end
                    end else begin
                        n_cur = up_sum[ssc_pkg::WIDTH_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_goal   <= '0;
            r_status <= ssc_pkg::ST_CLOSED;
        end else if (advance) begin
            r_cur    <= n_cur;
            r_goal   <= n_goal;
            r_status <= n_status;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pulse_width   <= n_cur;
            r_shutter_state <= n_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pulse_width   = r_pulse_width;
    assign o_shutter_state = r_shutter_state;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("upstream stalled with empty input register");

    a_init_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_operation == ssc_pkg::OP_INIT && r_want_open)
        |=> (r_status == ssc_pkg::ST_OPEN && r_cur == r_open_width
             && r_goal == r_cur))
        else $error("init to open did not set the open position");

    a_target_keeps_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_operation == ssc_pkg::OP_TARGET)
        |=> (r_cur == $past(r_cur) && r_status == $past(r_status)))
        else $error("set target changed width or status");

    a_frame_no_overshoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_operation == ssc_pkg::OP_FRAME && r_cur <= r_goal)
        |=> (r_cur <= r_goal && r_cur >= $past(r_cur)))
        else $error("upward frame overshot the target");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_pulse_width == r_cur && r_shutter_state == r_status))
        else $error("output word does not match controller state");

endmodule

// ===== tb/sv/servo_shutter_slew_controller_unit_tb.sv =====
`timescale 1ns / 100ps

module servo_shutter_slew_controller_unit_tb;

    localparam int RESET_CYCLES   = 11;
    localparam int HOLD_CYCLES    = 250;   // long output hold-off for the fill-up test
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on any port

    // one result word: pulse width and shutter status after an input word
    typedef struct packed {
        ssc_pkg::t_width pulse;
        ssc_pkg::t_state shutter;
    } t_servo_word;

    // clock, reset and every block input start at known values
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic [ssc_pkg::OP_W-1:0]      i_operation    = ssc_pkg::OP_INIT;
    logic                          i_want_open    = 1'b0;
    logic [ssc_pkg::WIDTH_W-1:0]   i_target_width = '0;
    logic                          i_out_stall    = 1'b0;
    logic                          psel           = 1'b0;
    logic                          penable        = 1'b0;
    logic                          pwrite         = 1'b0;
    logic [ssc_pkg::ADDR_W-1:0]    paddr          = '0;
    logic [ssc_pkg::DATA_W-1:0]    pwdata         = '0;

    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [ssc_pkg::WIDTH_W-1:0]   o_pulse_width;
    logic [ssc_pkg::STATE_W-1:0]   o_shutter_state;
    logic [ssc_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    // shadow copy of the configuration registers
    ssc_pkg::t_width cfg_open   = '0;
    ssc_pkg::t_width cfg_closed = '0;
    ssc_pkg::t_width cfg_step   = ssc_pkg::STEP_RESET;

    // shadow copy of the servo state
    ssc_pkg::t_width servo_cur    = '0;
    ssc_pkg::t_width servo_goal   = '0;
    ssc_pkg::t_state servo_status = ssc_pkg::ST_CLOSED;

    // predicted words, oldest first
    t_servo_word pending_positions[$];
    t_servo_word due_word;

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // sender idling is driven from the stimulus process itself
    bit in_idle_on  = 1'b0;
    // receiver idling and the long hold-off live in the stall process
    bit out_idle_on = 1'b0;
    int hold_seq    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int stall_left  = 0;

    servo_shutter_slew_controller_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_want_open     (i_want_open),
        .i_target_width  (i_target_width),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pulse_width   (o_pulse_width),
        .o_shutter_state (o_shutter_state),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #6 i_clk = ~i_clk;

    // one line per mismatch
    task automatic report_mismatch(string what, int unsigned got, int unsigned want_val);
        mismatch_count++;
        $display("[%0t] %s: got %0h, predicted %0h", $time, what, got, want_val);
    endtask

    // servo predictor: applies one input word to the shadow state
    function automatic t_servo_word advance_servo(ssc_pkg::t_op op, logic want,
                                                  ssc_pkg::t_width tgt);
        logic [ssc_pkg::WIDTH_W:0] sum;
        t_servo_word               res;
        case (op)
            ssc_pkg::OP_INIT: begin
                servo_status = want ? ssc_pkg::ST_OPEN : ssc_pkg::ST_CLOSED;
                servo_cur    = want ? cfg_open : cfg_closed;
                servo_goal   = servo_cur;
            end
            ssc_pkg::OP_CMD: begin
                // a command toward the position we already hold does nothing
                if (want && servo_status != ssc_pkg::ST_OPEN) begin
                    servo_goal   = cfg_open;
                    servo_status = ssc_pkg::ST_MOVING;
                end else if (!want && servo_status != ssc_pkg::ST_CLOSED) begin
                    servo_goal   = cfg_closed;
                    servo_status = ssc_pkg::ST_MOVING;
                end
            end
            ssc_pkg::OP_TARGET: servo_goal = tgt;
            default: begin
                if (servo_cur > servo_goal) begin
                    // downward: compare against the full distance, no wrap below zero
                    if (cfg_step >= servo_cur - servo_goal) begin
                        servo_cur = servo_goal;
                        if (servo_cur == cfg_open)
                            servo_status = ssc_pkg::ST_OPEN;
                    end else
                        servo_cur = servo_cur - cfg_step;
                end else if (servo_cur < servo_goal) begin
                    // upward: one bit wider sum so the top of range clamps
                    sum = {1'b0, servo_cur} + {1'b0, cfg_step};
                    if (sum >= {1'b0, servo_goal}) begin
                        servo_cur = servo_goal;
                        if (servo_cur == cfg_closed)
                            servo_status = ssc_pkg::ST_CLOSED;
                    end else
                        servo_cur = sum[ssc_pkg::WIDTH_W-1:0];
                end
            end
        endcase
        res.pulse   = servo_cur;
        res.shutter = servo_status;
        return res;
    endfunction

    // offer one word, optionally after an idle burst, and wait until it is taken
    task automatic send_word(ssc_pkg::t_op op, logic want, ssc_pkg::t_width tgt);
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_want_open    <= want;
        i_target_width <= tgt;
        do @(posedge i_clk); while (o_in_stall);
        pending_positions.push_back(advance_servo(op, want, tgt));
    endtask

    // drop valid, let every predicted word come out, then give the pipe time to settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one apb transfer: setup, access, then bus idle
    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [ssc_pkg::DATA_W-1:0] wdata,
                              output logic [ssc_pkg::DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // read a register back and compare with the shadow copy
    task automatic check_reg(logic [1:0] idx);
        logic [ssc_pkg::DATA_W-1:0] rd;
        ssc_pkg::t_width            want_val;
        apb_access(1'b0, idx, '0, rd);
        case (idx)
            ssc_pkg::REG_OPEN:   want_val = cfg_open;
            ssc_pkg::REG_CLOSED: want_val = cfg_closed;
            default:             want_val = cfg_step;
        endcase
        if (rd[ssc_pkg::WIDTH_W-1:0] !== want_val)
            report_mismatch("register readback", 32'(rd[ssc_pkg::WIDTH_W-1:0]),
                            32'(want_val));
    endtask

    task automatic program_reg(logic [1:0] idx, ssc_pkg::t_width val);
        logic [ssc_pkg::DATA_W-1:0] rd;
        apb_access(1'b1, idx, ssc_pkg::DATA_W'(val), rd);
        case (idx)
            ssc_pkg::REG_OPEN:   cfg_open = val;
            ssc_pkg::REG_CLOSED: cfg_closed = val;
            default:             cfg_step = val;
        endcase
        check_reg(idx);
    endtask

    // registers only change once the block has gone quiet
    task automatic apply_settings(ssc_pkg::t_width open_w, ssc_pkg::t_width closed_w,
                                  ssc_pkg::t_width step_w);
        wait_idle();
        program_reg(ssc_pkg::REG_OPEN, open_w);
        program_reg(ssc_pkg::REG_CLOSED, closed_w);
        program_reg(ssc_pkg::REG_STEP, step_w);
    endtask

    // mostly well-formed moves (command then a run of frames), the rest noise
    task automatic run_traffic(int n);
        int              sent;
        int              pick;
        logic            want;
        ssc_pkg::t_width tgt;
        sent = 0;
        while (sent < n) begin
            pick = int'($urandom_range(0, 99));
            want = 1'($urandom_range(0, 1));
            if (pick < 70) begin
                if (pick < 10) begin
                    send_word(ssc_pkg::OP_INIT, ~want, ssc_pkg::t_width'($urandom));
                    sent++;
                end
                send_word(ssc_pkg::OP_CMD, want, ssc_pkg::t_width'($urandom));
                sent++;
                repeat ($urandom_range(1, 24)) begin
                    send_word(ssc_pkg::OP_FRAME, 1'($urandom), ssc_pkg::t_width'($urandom));
                    sent++;
                end
            end else if (pick < 80) begin
                // retarget on or right beside one of the end positions, or anywhere
                tgt = want ? cfg_open : cfg_closed;
                if (pick < 76)
                    tgt = tgt + ssc_pkg::t_width'($urandom_range(0, 2)) - 16'd1;
                else
                    tgt = ssc_pkg::t_width'($urandom);
                send_word(ssc_pkg::OP_TARGET, 1'($urandom), tgt);
                sent++;
            end else begin
                send_word(ssc_pkg::t_op'($urandom_range(0, 3)), want,
                          ssc_pkg::t_width'($urandom));
                sent++;
            end
        end
    endtask

    // random open/closed pair with a step of the span divided by 1 to 16 (at least 1)
    task automatic random_settings();
        ssc_pkg::t_width open_w;
        ssc_pkg::t_width closed_w;
        ssc_pkg::t_width span;
        ssc_pkg::t_width step_w;
        open_w   = ssc_pkg::t_width'($urandom);
        closed_w = ssc_pkg::t_width'($urandom);
        span     = (open_w > closed_w) ? open_w - closed_w : closed_w - open_w;
        step_w   = span / ssc_pkg::t_width'($urandom_range(1, 16));
        if (step_w == 0)
            step_w = 16'd1;
        apply_settings(open_w, closed_w, step_w);
    endtask

    task automatic test_register_defaults();
        check_reg(ssc_pkg::REG_OPEN);
        check_reg(ssc_pkg::REG_CLOSED);
        check_reg(ssc_pkg::REG_STEP);
    endtask

    task automatic test_directed_moves();
        // open low, closed high: closing climbs, opening descends
        apply_settings(16'h0200, 16'hFF00, 16'h4000);
        send_word(ssc_pkg::OP_INIT, 1'b1, 16'hFFFF);
        send_word(ssc_pkg::OP_CMD, 1'b1, 16'h0000);      // already open, no move
        send_word(ssc_pkg::OP_CMD, 1'b0, 16'h5A5A);
        repeat (4) send_word(ssc_pkg::OP_FRAME, 1'b1, 16'hA5A5);  // lands closed from below
        send_word(ssc_pkg::OP_FRAME, 1'b0, 16'h0000);    // sitting on the goal
        send_word(ssc_pkg::OP_CMD, 1'b0, 16'hFFFF);      // already closed, no move
        send_word(ssc_pkg::OP_CMD, 1'b1, 16'h1234);
        repeat (4) send_word(ssc_pkg::OP_FRAME, 1'b0, 16'hFFFF);  // lands open from above
        // widest step with the end positions at the range limits
        apply_settings(16'h0000, 16'hFFFF, 16'hFFFF);
        send_word(ssc_pkg::OP_INIT, 1'b0, 16'h0001);
        send_word(ssc_pkg::OP_CMD, 1'b1, 16'h8000);
        send_word(ssc_pkg::OP_FRAME, 1'b0, 16'h7FFF);    // full-range drop onto open
        send_word(ssc_pkg::OP_TARGET, 1'b0, 16'h8000);
        send_word(ssc_pkg::OP_FRAME, 1'b1, 16'h0000);    // upward arrival off the closed width
        send_word(ssc_pkg::OP_TARGET, 1'b1, 16'hFFFF);
        send_word(ssc_pkg::OP_FRAME, 1'b0, 16'h0000);    // sum overflows 16 bits, clamps closed
        send_word(ssc_pkg::OP_TARGET, 1'b0, 16'h0001);
        send_word(ssc_pkg::OP_FRAME, 1'b1, 16'h0000);    // downward arrival off the open width
        send_word(ssc_pkg::OP_TARGET, 1'b1, 16'h0000);
        send_word(ssc_pkg::OP_FRAME, 1'b0, 16'hFFFF);    // step past zero, must not wrap
        // zero step freezes the servo
        apply_settings(16'h0100, 16'h0300, 16'h0000);
        send_word(ssc_pkg::OP_TARGET, 1'b0, 16'h1234);
        send_word(ssc_pkg::OP_FRAME, 1'b1, 16'h4321);
    endtask

    task automatic test_random_settings();
        ssc_pkg::t_width step_w;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    step_w = ssc_pkg::t_width'($urandom_range(16'h0800, 16'h2000));
                    apply_settings(16'h0000, 16'hFFFF, step_w);
                end
                1: apply_settings(16'hFFFF, 16'h0000, 16'hFFFF);
                3: begin
                    step_w = ssc_pkg::t_width'($urandom);
                    apply_settings(step_w, step_w, ssc_pkg::t_width'($urandom));
                end
                4: apply_settings(ssc_pkg::t_width'($urandom), ssc_pkg::t_width'($urandom),
                                  16'h0000);
                5: apply_settings(ssc_pkg::t_width'($urandom), ssc_pkg::t_width'($urandom),
                                  ssc_pkg::t_width'($urandom_range(1, 255)));
                default: random_settings();
            endcase
            run_traffic(ph == 4 ? 60 : 190);
        end
    endtask

    // output held off for a long stretch while words keep coming
    task automatic test_output_hold();
        random_settings();
        hold_seq <= hold_seq + 1;
        run_traffic(30);
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        in_idle_on = 1'b0;
        out_idle_on <= 1'b0;
        random_settings();
        run_traffic(200);
    endtask

    // receiver: long hold-off first, then short random stall bursts
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= (hold_left > 1);
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= (stall_left > 1);
        end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= int'($urandom_range(1, 9));
            i_out_stall <= 1'b1;
        end else
            i_out_stall <= 1'b0;
    end

    // result checker: every taken word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_positions.size() == 0)
                report_mismatch("word with nothing predicted", 32'(o_pulse_width), 0);
            else begin
                due_word = pending_positions.pop_front();
                if (o_pulse_width !== due_word.pulse)
                    report_mismatch("pulse_width", 32'(o_pulse_width),
                                    32'(due_word.pulse));
                if (o_shutter_state !== due_word.shutter)
                    report_mismatch("shutter_state", 32'(o_shutter_state),
                                    32'(due_word.shutter));
            end
        end
    end

    // watchdog: nothing moving on any port for too long ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            quiet_cycles <= 0;
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        in_idle_on = 1'b1;
        out_idle_on <= 1'b1;
        test_register_defaults();
        test_directed_moves();
        test_random_settings();
        test_output_hold();
        test_steady_stream();
        wait_idle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
